[rtl/encoder_speed_pid_drive_defines.svh]
// Assertion macros for the speed controller.
`ifndef ENCODER_SPEED_PID_DRIVE_DEFINES_SVH
`define ENCODER_SPEED_PID_DRIVE_DEFINES_SVH
`ifndef SYNTHESIS
`define ESPD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ESPD_ASSERT_RST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESPD_ASSERT(label, clk, rst, prop, msg)
`define ESPD_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[rtl/espd_pkg.sv]
`timescale 1ns / 1ps
package espd_pkg;

   typedef struct packed {
      logic [15:0] encoder_count;
      logic [17:0] reference_speed;
   } req_type;

   typedef struct packed {
      logic [9:0]  drive_value;
      logic [17:0] measured_speed;
   } rsp_type;

   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_IDX_BITS  = 3;

   localparam logic [CSR_IDX_BITS-1:0] REG_SPEED_SCALE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_SPEED_LIMIT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_KP_GAIN     = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_KI_DT_GAIN  = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] REG_KD_DT_GAIN  = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] REG_DRIVE_MAX   = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] REG_DRIVE_MIN   = 3'd6;

   localparam logic [15:0] SPEED_SCALE_RST = 16'd978;
   localparam logic [17:0] SPEED_LIMIT_RST = 18'd87040;
   localparam logic [9:0]  DRIVE_MAX_RST   = 10'd90;
   localparam logic [9:0]  DRIVE_MIN_RST   = 10'd0;

   localparam int ACC_BITS  = 58;
   localparam int PROD_BITS = 38;
   localparam int MUL_SPLIT = 20;
   localparam int Q_SHIFT   = 16;

   localparam logic [39:0] SUM_MAX = {1'b0, {39{1'b1}}};
   localparam logic [39:0] SUM_MIN = {1'b1, {39{1'b0}}};

   localparam int STEP_BITS = 4;

   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_CHANGE = 3'd1;
   localparam logic [2:0] OP_SPEED  = 3'd2;
   localparam logic [2:0] OP_ERR    = 3'd3;
   localparam logic [2:0] OP_DIFF   = 3'd4;
   localparam logic [2:0] OP_DRIVE  = 3'd5;

   localparam logic [2:0] MUL_NONE   = 3'd0;
   localparam logic [2:0] MUL_SPD_LO = 3'd1;
   localparam logic [2:0] MUL_SPD_HI = 3'd2;
   localparam logic [2:0] MUL_KP     = 3'd3;
   localparam logic [2:0] MUL_KD     = 3'd4;
   localparam logic [2:0] MUL_KI_LO  = 3'd5;
   localparam logic [2:0] MUL_KI_HI  = 3'd6;

   localparam logic [1:0] JMP_NEXT        = 2'd0;
   localparam logic [1:0] JMP_CHG_HI_ZERO = 2'd1;
   localparam logic [1:0] JMP_KI_ZERO     = 2'd2;
   localparam logic [1:0] JMP_END         = 2'd3;

   typedef struct packed {
      logic [2:0]           op;
      logic [2:0]           mul;
      logic                 acc_clr;
      logic [1:0]           jmp;
      logic [STEP_BITS-1:0] target;
   } ctrl_word_type;

   localparam logic [STEP_BITS-1:0] UCODE_LAST = 4'd11;

   function automatic ctrl_word_type ucode(input logic [STEP_BITS-1:0] pc);
      ctrl_word_type cw;
      cw = '{op: OP_NONE, mul: MUL_NONE, acc_clr: 1'b0, jmp: JMP_NEXT, target: '0};
      case (pc)
         4'd0: begin
            cw.op      = OP_CHANGE;
            cw.acc_clr = 1'b1;
         end
         4'd1: begin
            cw.mul    = MUL_SPD_LO;
            cw.jmp    = JMP_CHG_HI_ZERO;
            cw.target = 4'd3;
         end
         4'd2: cw.mul = MUL_SPD_HI;
         4'd3: cw.op  = OP_NONE;
         4'd4: begin
            cw.op      = OP_SPEED;
            cw.acc_clr = 1'b1;
         end
         4'd5: cw.op = OP_ERR;
         4'd6: begin
            cw.op  = OP_DIFF;
            cw.mul = MUL_KP;
         end
         4'd7: begin
            cw.mul    = MUL_KD;
            cw.jmp    = JMP_KI_ZERO;
            cw.target = 4'd10;
         end
         4'd8:  cw.mul = MUL_KI_LO;
         4'd9:  cw.mul = MUL_KI_HI;
         4'd10: cw.op  = OP_NONE;
         4'd11: begin
            cw.op  = OP_DRIVE;
            cw.jmp = JMP_END;
         end
         default: cw.jmp = JMP_END;
      endcase
      return cw;
   endfunction

endpackage

[rtl/encoder_speed_pid_drive.sv]
`timescale 1ns / 1ps
// A request is accepted only while the sequencer is idle, so a new request waits until the
// last result is issued. The sequencer runs one step per cycle, holding at the drive step
// while an earlier result is untaken, through a single shared 17x21 multiplier, skipping
// the high count product when zero and the integral products when ki_dt_gain is zero.
// Reset: synchronous; clears controller state and sequencer, restores register defaults.
`include "encoder_speed_pid_drive_defines.svh"
module encoder_speed_pid_drive #(
   parameter int COUNT_BITS     = 16,
   parameter int WRAP_THRESHOLD = 30000
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  espd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output espd_pkg::rsp_type                rsp_data,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [espd_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import espd_pkg::*;

   localparam int PosBits = (COUNT_BITS < 16) ? COUNT_BITS : 16;

   logic [15:0] speed_scale_ff;
   logic [17:0] speed_limit_ff;
   logic [15:0] kp_ff;
   logic [15:0] ki_ff;
   logic [15:0] kd_ff;
   logic [9:0]  drive_max_ff;
   logic [9:0]  drive_min_ff;

   logic                    csr_wr;
   logic [CSR_IDX_BITS-1:0] csr_idx;

   logic                  busy_ff, busy_in;
   logic [STEP_BITS-1:0]  pc_ff, pc_in;
   ctrl_word_type         cw;
   logic                  step_en;
   logic                  step_hold;
   logic                  accept;

   logic [PosBits-1:0]    pos_ff;
   logic [17:0]           ref_ff;
   logic [PosBits-1:0]    last_count_ff;
   logic signed [18:0]    last_error_ff;
   logic signed [39:0]    error_sum_ff;

   logic [COUNT_BITS-1:0] change_ff, change_in;
   logic [PosBits-1:0]    delta;
   logic                  wrap;
   logic [31:0]           chg_wide;
   logic                  chg_hi_zero;

   logic [17:0]           speed_ff, speed_in;
   logic signed [ACC_BITS-1:0] limit_ext;
   logic signed [18:0]    err_ff, err_in;
   logic signed [19:0]    diff_ff, diff_in;
   logic signed [40:0]    sum_wide;
   logic signed [39:0]    sum_new_ff, sum_new_in;

   logic signed [16:0]    mul_a;
   logic signed [20:0]    mul_b;
   logic                  mul_sh;
   logic signed [PROD_BITS-1:0] prod_ff, prod_in;
   logic                  prod_vld_ff, prod_vld_in;
   logic                  prod_sh_ff;
   logic signed [ACC_BITS-1:0] prod_ext, prod_add;
   logic signed [ACC_BITS-1:0] acc_ff, acc_in;

   logic signed [ACC_BITS-1:0]        acc_bias;
   logic signed [ACC_BITS-Q_SHIFT-1:0] quot;
   logic signed [ACC_BITS-Q_SHIFT-1:0] max_ext, min_ext;
   logic [9:0]            drive_in;

   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[CSR_ADDR_BITS-1:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_scale_ff <= SPEED_SCALE_RST;
         speed_limit_ff <= SPEED_LIMIT_RST;
         kp_ff          <= '0;
         ki_ff          <= '0;
         kd_ff          <= '0;
         drive_max_ff   <= DRIVE_MAX_RST;
         drive_min_ff   <= DRIVE_MIN_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_SPEED_SCALE: speed_scale_ff <= csr_pwdata[15:0];
            REG_SPEED_LIMIT: speed_limit_ff <= csr_pwdata[17:0];
            REG_KP_GAIN:     kp_ff          <= csr_pwdata[15:0];
            REG_KI_DT_GAIN:  ki_ff          <= csr_pwdata[15:0];
            REG_KD_DT_GAIN:  kd_ff          <= csr_pwdata[15:0];
            REG_DRIVE_MAX:   drive_max_ff   <= csr_pwdata[9:0];
            REG_DRIVE_MIN:   drive_min_ff   <= csr_pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_SPEED_SCALE: csr_prdata = 32'(speed_scale_ff);
         REG_SPEED_LIMIT: csr_prdata = 32'(speed_limit_ff);
         REG_KP_GAIN:     csr_prdata = 32'(kp_ff);
         REG_KI_DT_GAIN:  csr_prdata = 32'(ki_ff);
         REG_KD_DT_GAIN:  csr_prdata = 32'(kd_ff);
         REG_DRIVE_MAX:   csr_prdata = 32'(drive_max_ff);
         REG_DRIVE_MIN:   csr_prdata = 32'(drive_min_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // sequencer
   assign cw        = ucode(pc_ff);
   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   assign step_hold = (cw.op == OP_DRIVE) && rsp_valid_ff && !rsp_ready;
   assign step_en   = busy_ff && !step_hold;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (accept) begin
         busy_in = 1'b1;
         pc_in   = '0;
      end else if (step_en) begin
         case (cw.jmp)
            JMP_NEXT:        pc_in = pc_ff + 1'b1;
            JMP_CHG_HI_ZERO: pc_in = chg_hi_zero ? cw.target : pc_ff + 1'b1;
            JMP_KI_ZERO:     pc_in = (ki_ff == 16'd0) ? cw.target : pc_ff + 1'b1;
            JMP_END: begin
               busy_in = 1'b0;
               pc_in   = '0;
            end
            default: pc_in = '0;
         endcase
      end
   end

   // count change with wrap handling
   assign delta = (pos_ff >= last_count_ff) ? pos_ff - last_count_ff
                                            : last_count_ff - pos_ff;
   assign wrap  = 33'(delta) > 33'(WRAP_THRESHOLD);
   assign change_in = wrap ? ({COUNT_BITS{1'b1}} - COUNT_BITS'(delta)) : COUNT_BITS'(delta);
   assign chg_wide    = 32'(change_ff);
   assign chg_hi_zero = (chg_wide[31:MUL_SPLIT] == '0);

   // shared multiplier
   always_comb begin
      mul_a  = '0;
      mul_b  = '0;
      mul_sh = 1'b0;
      case (cw.mul)
         MUL_SPD_LO: begin
            mul_a = {1'b0, speed_scale_ff};
            mul_b = {1'b0, chg_wide[MUL_SPLIT-1:0]};
         end
         MUL_SPD_HI: begin
            mul_a  = {1'b0, speed_scale_ff};
            mul_b  = {9'b0, chg_wide[31:MUL_SPLIT]};
            mul_sh = 1'b1;
         end
         MUL_KP: begin
            mul_a = {kp_ff[15], kp_ff};
            mul_b = {{2{err_ff[18]}}, err_ff};
         end
         MUL_KD: begin
            mul_a = {kd_ff[15], kd_ff};
            mul_b = {diff_ff[19], diff_ff};
         end
         MUL_KI_LO: begin
            mul_a = {ki_ff[15], ki_ff};
            mul_b = {1'b0, sum_new_ff[MUL_SPLIT-1:0]};
         end
         MUL_KI_HI: begin
            mul_a  = {ki_ff[15], ki_ff};
            mul_b  = {sum_new_ff[39], sum_new_ff[39:MUL_SPLIT]};
            mul_sh = 1'b1;
         end
         default: ;
      endcase
   end

   assign prod_in     = mul_a * mul_b;
   assign prod_vld_in = step_en && (cw.mul != MUL_NONE);
   assign prod_ext    = ACC_BITS'(prod_ff);
   assign prod_add    = prod_sh_ff ? (prod_ext <<< MUL_SPLIT) : prod_ext;

   always_comb begin
      acc_in = acc_ff;
      if (step_en && cw.acc_clr) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + prod_add;
      end
   end

   // speed, error, sum
   assign limit_ext = ACC_BITS'(speed_limit_ff);
   assign speed_in  = (acc_ff > limit_ext) ? 18'd0 : acc_ff[17:0];
   assign err_in    = $signed({1'b0, ref_ff}) - $signed({1'b0, speed_ff});
   assign diff_in   = $signed({err_ff[18], err_ff}) - $signed({last_error_ff[18], last_error_ff});
   assign sum_wide  = $signed({error_sum_ff[39], error_sum_ff}) + 41'(err_ff);

   always_comb begin
      if (sum_wide[40] != sum_wide[39]) begin
         sum_new_in = sum_wide[40] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_new_in = sum_wide[39:0];
      end
   end

   // truncate toward zero and clamp
   assign acc_bias = acc_ff + (acc_ff[ACC_BITS-1] ? ACC_BITS'((1 << Q_SHIFT) - 1)
                                                  : ACC_BITS'(0));
   assign quot     = acc_bias[ACC_BITS-1:Q_SHIFT];
   assign max_ext  = (ACC_BITS-Q_SHIFT)'(drive_max_ff);
   assign min_ext  = (ACC_BITS-Q_SHIFT)'(drive_min_ff);

   always_comb begin
      if (quot > max_ext) begin
         drive_in = drive_max_ff;
      end else if (quot < min_ext) begin
         drive_in = drive_min_ff;
      end else begin
         drive_in = quot[9:0];
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pc_ff         <= '0;
         prod_vld_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         last_count_ff <= '0;
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else begin
         busy_ff     <= busy_in;
         pc_ff       <= pc_in;
         prod_vld_ff <= prod_vld_in;
         if (step_en && (cw.op == OP_DRIVE)) begin
            rsp_valid_ff  <= 1'b1;
            last_count_ff <= pos_ff;
            last_error_ff <= err_ff;
            error_sum_ff  <= sum_new_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pos_ff <= req_data.encoder_count[PosBits-1:0];
         ref_ff <= req_data.reference_speed;
      end
      prod_ff    <= prod_in;
      prod_sh_ff <= mul_sh;
      acc_ff     <= acc_in;
      if (step_en) begin
         case (cw.op)
            OP_CHANGE: change_ff <= change_in;
            OP_SPEED:  speed_ff  <= speed_in;
            OP_ERR:    err_ff    <= err_in;
            OP_DIFF: begin
               diff_ff    <= diff_in;
               sum_new_ff <= sum_new_in;
            end
            OP_DRIVE: begin
               rsp_data_ff.drive_value    <= drive_in;
               rsp_data_ff.measured_speed <= speed_ff;
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `ESPD_ASSERT(a_pc_range, clock, reset, busy_ff |-> (pc_ff <= UCODE_LAST), "step out of range")
   `ESPD_ASSERT(a_start, clock, reset, accept |=> (busy_ff && (pc_ff == '0)), "no start")
   `ESPD_ASSERT(a_rsp_src, clock, reset, $rose(rsp_valid_ff) |-> ($past(pc_ff) == UCODE_LAST), "stray result")
   `ESPD_ASSERT(a_idle_prod, clock, reset, !busy_ff |-> !prod_vld_ff, "product while idle")
   `ESPD_ASSERT_RST(a_reset, clock, reset |=> (!busy_ff && !rsp_valid_ff), "reset not clean")

endmodule
